// ----- rtl/fgrt_pkg.sv -----
// fgrt_pkg: shared types and constants of the frame gap retransmit tracker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fgrt_pkg;

    localparam int PT_W         = 11;
    localparam int CH_W         = 3;
    localparam int NUM_W        = 32;
    localparam int MOVE_W       = 12;
    localparam int REQ_W        = 5;
    localparam int MAX_REQUESTS = 31;
    localparam int POINT_MOD    = 2048;

    localparam logic [31:0] BASE_ADDR = 32'd81;
    localparam logic [31:0] ADDR_STEP = 32'd10;

    typedef enum logic [1:0] {
        KIND_IGNORED    = 2'd0,
        KIND_ACCEPTED   = 2'd1,
        KIND_RETRANSMIT = 2'd2,
        KIND_REQUEST    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SEARCH,
        ST_RETX,
        ST_DIV,
        ST_REQ,
        ST_ACCEPT
    } state_t;

    typedef struct packed {
        logic  take;
        logic  scan_init;
        logic  scan_step;
        logic  div_start;
        logic  req_init;
        logic  free_step;
        logic  emit;
        kind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic first;
        logic hit;
        logic scan_end;
        logic div_done;
        logic reqs_left;
        logic slot_busy;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [PT_W-1:0]  pt;
        logic [NUM_W-1:0] num;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/fgrt_div.sv -----
// fgrt_div: division of the pointer move by a fixed divisor through a constant
// reciprocal multiply, result registered in the cycle after start. Uses fgrt_pkg.
`default_nettype none

module fgrt_div #(
    parameter int DIVISOR = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [fgrt_pkg::MOVE_W-1:0] dividend,
    output logic      [fgrt_pkg::MOVE_W-1:0] quotient,
    output logic                             done
);

    localparam int MOVE_W = fgrt_pkg::MOVE_W;
    localparam int LOG_D  = $clog2(DIVISOR);
    localparam int SHIFT  = MOVE_W + LOG_D;
    localparam int RW     = MOVE_W + 1;
    localparam int PW     = MOVE_W + RW;
    // ceil(2^SHIFT / DIVISOR), exact for every dividend below 2^MOVE_W
    localparam longint RECIP_L =
        ((longint'(1) <<< SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    logic [PW-1:0]     product;
    logic [MOVE_W-1:0] quot_reg;
    logic              done_reg;

    assign product = {{RW{1'b0}}, dividend} * {{MOVE_W{1'b0}}, RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= MOVE_W'(product >> SHIFT);
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ----- rtl/fgrt_ctrl.sv -----
// fgrt_ctrl: sequencer of the tracker; steps each frame through classify and,
// where needed, table scan, gap division and request emission. Uses fgrt_pkg.
`default_nettype none

module fgrt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              frame_valid,
    input  wire fgrt_pkg::status_t status,
    output fgrt_pkg::cmd_t         cmd,
    output logic                   frame_stall
);

    fgrt_pkg::state_t state_reg;
    fgrt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fgrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fgrt_pkg::ST_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = fgrt_pkg::ST_CLASSIFY;
                end
            end
            fgrt_pkg::ST_CLASSIFY:
            begin
                if (!status.found || status.first)
                begin
                    if (status.out_free)
                    begin
                        state_next = fgrt_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = fgrt_pkg::ST_SEARCH;
                end
            end
            fgrt_pkg::ST_SEARCH:
            begin
                priority if (status.hit)
                begin
                    state_next = fgrt_pkg::ST_RETX;
                end
                else if (status.scan_end)
                begin
                    state_next = fgrt_pkg::ST_DIV;
                end
            end
            fgrt_pkg::ST_RETX:
            begin
                if (status.out_free)
                begin
                    state_next = fgrt_pkg::ST_IDLE;
                end
            end
            fgrt_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = fgrt_pkg::ST_REQ;
                end
            end
            fgrt_pkg::ST_REQ:
            begin
                if (!status.reqs_left)
                begin
                    state_next = fgrt_pkg::ST_ACCEPT;
                end
            end
            fgrt_pkg::ST_ACCEPT:
            begin
                if (status.out_free)
                begin
                    state_next = fgrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fgrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        frame_stall = 1'b1;
        unique case (state_reg)
            fgrt_pkg::ST_IDLE:
            begin
                frame_stall = 1'b0;
                cmd.take    = frame_valid;
            end
            fgrt_pkg::ST_CLASSIFY:
            begin
                priority if (!status.found)
                begin
                    cmd.emit      = status.out_free;
                    cmd.emit_kind = fgrt_pkg::KIND_IGNORED;
                end
                else if (status.first)
                begin
                    cmd.emit      = status.out_free;
                    cmd.emit_kind = fgrt_pkg::KIND_ACCEPTED;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                end
            end
            fgrt_pkg::ST_SEARCH:
            begin
                cmd.scan_step = !status.hit && !status.scan_end;
                cmd.div_start = !status.hit && status.scan_end;
            end
            fgrt_pkg::ST_RETX:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = fgrt_pkg::KIND_RETRANSMIT;
            end
            fgrt_pkg::ST_DIV:
            begin
                cmd.req_init = status.div_done;
            end
            fgrt_pkg::ST_REQ:
            begin
                if (status.reqs_left)
                begin
                    if (status.slot_busy)
                    begin
                        cmd.free_step = 1'b1;
                    end
                    else
                    begin
                        cmd.emit      = status.out_free;
                        cmd.emit_kind = fgrt_pkg::KIND_REQUEST;
                    end
                end
            end
            fgrt_pkg::ST_ACCEPT:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = fgrt_pkg::KIND_ACCEPTED;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/fgrt_dp.sv -----
// fgrt_dp: datapath of the tracker: channel state, missing-frame table,
// gap divider and result register. Uses fgrt_pkg and fgrt_div.
`default_nettype none

module fgrt_dp #(
    parameter int SAMPLES_PER_FRAME = 64,
    parameter int CHANNELS          = 8,
    parameter int PENDING_DEPTH     = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [7:0]                     cfg_data,
    input  wire logic [31:0]                    source_ip,
    input  wire logic [fgrt_pkg::PT_W-1:0]      point_index,
    input  wire logic                           result_stall,
    input  wire fgrt_pkg::cmd_t                 cmd,
    output fgrt_pkg::status_t                   status,
    output logic                                result_valid,
    output logic [1:0]                          kind,
    output logic [fgrt_pkg::CH_W-1:0]           channel,
    output logic [fgrt_pkg::PT_W-1:0]           request_point,
    output logic [fgrt_pkg::NUM_W-1:0]          frame_number,
    output logic                                table_full,
    output logic                                last
);

    localparam int PT_W   = fgrt_pkg::PT_W;
    localparam int CH_W   = fgrt_pkg::CH_W;
    localparam int NUM_W  = fgrt_pkg::NUM_W;
    localparam int MOVE_W = fgrt_pkg::MOVE_W;
    localparam int REQ_W  = fgrt_pkg::REQ_W;
    localparam int IW     = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int FW     = $clog2(PENDING_DEPTH + 1);
    localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [PT_W-1:0]   SPF_PT    = PT_W'(SAMPLES_PER_FRAME);
    localparam logic [MOVE_W-1:0] WRAP      = MOVE_W'(fgrt_pkg::POINT_MOD);
    localparam logic [PT_W-1:0]   MAX_LOST  = PT_W'(fgrt_pkg::MAX_REQUESTS);
    localparam logic [REQ_W-1:0]  MAX_EMIT  = REQ_W'(fgrt_pkg::MAX_REQUESTS);
    localparam logic [IW-1:0]     LAST_IDX  = IW'(PENDING_DEPTH - 1);
    localparam logic [FW-1:0]     FREE_END  = FW'(PENDING_DEPTH);

    logic [7:0]             enable_reg;
    logic [CH_W-1:0]        ch_reg;
    logic                   found_reg;
    logic [PT_W-1:0]        now_reg;
    logic [NUM_W-1:0]       count_reg [CHANNELS];
    logic [PT_W-1:0]        prev_reg  [CHANNELS];
    logic [PT_W-1:0]        lost_reg;
    logic                   over_reg;

    logic [PENDING_DEPTH-1:0] valid_reg;
    fgrt_pkg::entry_t       pend_mem [PENDING_DEPTH];
    fgrt_pkg::entry_t       rd_entry_reg;
    logic [IW-1:0]          sidx_reg;
    logic [IW-1:0]          ridx_reg;
    logic                   rd_live_reg;
    logic                   rd_vld_reg;
    logic [FW-1:0]          fidx_reg;

    logic [REQ_W-1:0]       left_reg;
    logic [PT_W-1:0]        req_pt_reg;
    logic [NUM_W-1:0]       req_num_reg;

    logic                   result_valid_reg;
    fgrt_pkg::kind_t        kind_reg;
    logic [CH_W-1:0]        ch_out_reg;
    logic [PT_W-1:0]        pt_out_reg;
    logic [NUM_W-1:0]       num_out_reg;
    logic                   full_out_reg;
    logic                   last_out_reg;

    logic                   match_found;
    logic [CH_W-1:0]        match_ch;
    logic [CIW-1:0]         chi;
    logic [NUM_W-1:0]       cnt_inc;
    logic [PT_W-1:0]        prev_cur;
    logic [MOVE_W-1:0]      move;
    logic [MOVE_W-1:0]      quot;
    logic                   div_done;
    logic [PT_W-1:0]        lost_calc;
    logic                   over_calc;
    logic [REQ_W-1:0]       emit_calc;
    logic                   free_end;
    logic                   out_free;
    logic                   mem_we;
    fgrt_pkg::entry_t       req_entry;
    logic [NUM_W-1:0]       accept_num;

    always_comb
    begin
        match_found = 1'b0;
        match_ch    = '0;
        for (int c = CHANNELS - 1; c >= 0; c--)
        begin
            if (enable_reg[c] &&
                source_ip == fgrt_pkg::BASE_ADDR + fgrt_pkg::ADDR_STEP * 32'(c))
            begin
                match_found = 1'b1;
                match_ch    = CH_W'(c);
            end
        end
    end

    assign chi        = ch_reg[CIW-1:0];
    assign cnt_inc    = count_reg[chi] + NUM_W'(1);
    assign prev_cur   = prev_reg[chi];
    assign accept_num = cnt_inc + NUM_W'(lost_reg);

    // now == prev is a full wrap
    assign move = (now_reg > prev_cur) ? ({1'b0, now_reg} - {1'b0, prev_cur})
                                       : (WRAP + {1'b0, now_reg} - {1'b0, prev_cur});

    fgrt_div #(
        .DIVISOR (SAMPLES_PER_FRAME)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (move),
        .quotient (quot),
        .done     (div_done)
    );

    assign lost_calc = (quot == '0) ? '0 : PT_W'(quot - MOVE_W'(1));
    assign over_calc = (lost_calc > MAX_LOST);
    assign emit_calc = over_calc ? MAX_EMIT : lost_calc[REQ_W-1:0];

    assign free_end  = (fidx_reg == FREE_END);
    assign out_free  = !result_valid_reg || !result_stall;
    assign mem_we    = cmd.emit && (cmd.emit_kind == fgrt_pkg::KIND_REQUEST) && !free_end;

    assign req_entry.ch  = ch_reg;
    assign req_entry.pt  = req_pt_reg;
    assign req_entry.num = req_num_reg;

    assign status.found     = found_reg;
    assign status.first     = (cnt_inc == NUM_W'(1));
    assign status.hit       = rd_live_reg && rd_vld_reg && (rd_entry_reg.ch == ch_reg) &&
                              (rd_entry_reg.pt == now_reg);
    assign status.scan_end  = rd_live_reg && (ridx_reg == LAST_IDX);
    assign status.div_done  = div_done;
    assign status.reqs_left = (left_reg != '0);
    assign status.slot_busy = !free_end && valid_reg[fidx_reg[IW-1:0]];
    assign status.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pend_mem[fidx_reg[IW-1:0]] <= req_entry;
        end
        if (cmd.scan_step)
        begin
            rd_entry_reg <= pend_mem[sidx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '0;
            found_reg   <= 1'b0;
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            sidx_reg    <= '0;
            fidx_reg    <= '0;
            left_reg    <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c] <= '0;
                prev_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_data;
            end
            if (cmd.take)
            begin
                found_reg <= match_found;
            end
            if (cmd.scan_init)
            begin
                sidx_reg    <= '0;
                rd_live_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_vld_reg  <= valid_reg[sidx_reg];
                sidx_reg    <= sidx_reg + IW'(1);
                rd_live_reg <= 1'b1;
            end
            if (cmd.req_init)
            begin
                left_reg <= emit_calc;
                fidx_reg <= '0;
            end
            else if (cmd.free_step)
            begin
                fidx_reg <= fidx_reg + FW'(1);
            end
            if (cmd.emit)
            begin
                unique case (cmd.emit_kind)
                    fgrt_pkg::KIND_RETRANSMIT:
                    begin
                        valid_reg[ridx_reg] <= 1'b0;
                    end
                    fgrt_pkg::KIND_REQUEST:
                    begin
                        left_reg <= left_reg - REQ_W'(1);
                        if (!free_end)
                        begin
                            valid_reg[fidx_reg[IW-1:0]] <= 1'b1;
                            fidx_reg <= fidx_reg + FW'(1);
                        end
                    end
                    fgrt_pkg::KIND_ACCEPTED:
                    begin
                        count_reg[chi] <= accept_num;
                        prev_reg[chi]  <= now_reg;
                    end
                    fgrt_pkg::KIND_IGNORED:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ch_reg   <= match_ch;
            now_reg  <= point_index;
            lost_reg <= '0;
            over_reg <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            ridx_reg <= sidx_reg;
        end
        if (cmd.req_init)
        begin
            lost_reg    <= lost_calc;
            over_reg    <= over_calc;
            req_pt_reg  <= prev_cur + SPF_PT;
            req_num_reg <= cnt_inc;
        end
        else if (cmd.emit && cmd.emit_kind == fgrt_pkg::KIND_REQUEST)
        begin
            req_pt_reg  <= req_pt_reg + SPF_PT;
            req_num_reg <= req_num_reg + NUM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.emit_kind;
            unique case (cmd.emit_kind)
                fgrt_pkg::KIND_IGNORED:
                begin
                    ch_out_reg   <= '0;
                    pt_out_reg   <= now_reg;
                    num_out_reg  <= '0;
                    full_out_reg <= 1'b0;
                    last_out_reg <= 1'b1;
                end
                fgrt_pkg::KIND_ACCEPTED:
                begin
                    ch_out_reg   <= ch_reg;
                    pt_out_reg   <= now_reg;
                    num_out_reg  <= accept_num;
                    full_out_reg <= over_reg;
                    last_out_reg <= 1'b1;
                end
                fgrt_pkg::KIND_RETRANSMIT:
                begin
                    ch_out_reg   <= ch_reg;
                    pt_out_reg   <= now_reg;
                    num_out_reg  <= rd_entry_reg.num;
                    full_out_reg <= 1'b0;
                    last_out_reg <= 1'b1;
                end
                fgrt_pkg::KIND_REQUEST:
                begin
                    ch_out_reg   <= ch_reg;
                    pt_out_reg   <= req_pt_reg;
                    num_out_reg  <= req_num_reg;
                    full_out_reg <= free_end;
                    last_out_reg <= 1'b0;
                end
                default:
                begin
                    ch_out_reg   <= '0;
                    pt_out_reg   <= now_reg;
                    num_out_reg  <= '0;
                    full_out_reg <= 1'b0;
                    last_out_reg <= 1'b1;
                end
            endcase
        end
    end

    assign result_valid  = result_valid_reg;
    assign kind          = kind_reg;
    assign channel       = ch_out_reg;
    assign request_point = pt_out_reg;
    assign frame_number  = num_out_reg;
    assign table_full    = full_out_reg;
    assign last          = last_out_reg;

endmodule

`default_nettype wire

// ----- rtl/frame_gap_retransmit_tracker.sv -----
// frame_gap_retransmit_tracker: top level, joins the sequencer and datapath.
// Uses fgrt_pkg, fgrt_ctrl, fgrt_dp (and through it fgrt_div).
//
//   channel  | handshake               | beat
//   ---------+-------------------------+-------------------------------------
//   frame    | frame_valid/frame_stall | source_ip, point_index
//   result   | result_valid/result_stall | kind, channel, request_point,
//            |                         | frame_number, table_full, last
//   cfg      | cfg_valid/cfg_ready     | cfg_data (channel enable mask)
//
// One frame at a time. An ignored or first frame is classified and answered.
// A retransmitted frame is found by the one-entry-per-cycle table scan. A
// frame with a gap scans the whole table, divides the gap, emits its requests,
// each after a free-slot scan, then the accepted result; result stall holds any.
// Reset clears channel state and valid bits at once; no clearing pass.
`default_nettype none

module frame_gap_retransmit_tracker #(
    parameter int SAMPLES_PER_FRAME = 64,
    parameter int CHANNELS          = 8,
    parameter int PENDING_DEPTH     = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        frame_valid,
    output logic             frame_stall,
    input  wire logic [31:0] source_ip,
    input  wire logic [10:0] point_index,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       kind,
    output logic [2:0]       channel,
    output logic [10:0]      request_point,
    output logic [31:0]      frame_number,
    output logic             table_full,
    output logic             last
);

    fgrt_pkg::cmd_t    cmd;
    fgrt_pkg::status_t status;

    assign cfg_ready = 1'b1;

    fgrt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .status      (status),
        .cmd         (cmd),
        .frame_stall (frame_stall)
    );

    fgrt_dp #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME),
        .CHANNELS          (CHANNELS),
        .PENDING_DEPTH     (PENDING_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .source_ip     (source_ip),
        .point_index   (point_index),
        .result_stall  (result_stall),
        .cmd           (cmd),
        .status        (status),
        .result_valid  (result_valid),
        .kind          (kind),
        .channel       (channel),
        .request_point (request_point),
        .frame_number  (frame_number),
        .table_full    (table_full),
        .last          (last)
    );

endmodule

`default_nettype wire

// ----- rtl/fgrt_checker.sv -----
// fgrt_checker: port-level assertions for the tracker, bound to the top level.
// Uses fgrt_pkg for the result kind codes.
`default_nettype none

module fgrt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        frame_valid,
    input wire logic        frame_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [1:0]  kind,
    input wire logic [2:0]  channel,
    input wire logic [10:0] request_point,
    input wire logic [31:0] frame_number,
    input wire logic        table_full,
    input wire logic        last
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(kind) &&
        $stable(channel) && $stable(request_point) && $stable(frame_number) &&
        $stable(table_full) && $stable(last))
        else $error("stalled result beat changed");

    a_ignored_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == fgrt_pkg::KIND_IGNORED |->
        channel == 3'd0 && frame_number == 32'd0 && !table_full && last)
        else $error("ignored result carries channel, number or flags");

    a_last_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((kind == fgrt_pkg::KIND_REQUEST) == !last))
        else $error("last flag disagrees with result kind");

    a_retx_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == fgrt_pkg::KIND_RETRANSMIT |-> !table_full)
        else $error("retransmitted result flags table full");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("new frame taken before previous one finished");

endmodule

bind frame_gap_retransmit_tracker fgrt_checker u_fgrt_checker (.*);

`default_nettype wire

// ----- tb/fgrt_checker.sv -----
`timescale 1ns / 100ps
// fgrt_scoreboard: watches the frame, result and cfg channels of the tracker,
// predicts every result beat from its own copy of the channel state and compares them.
// Depends on fgrt_pkg.
module fgrt_scoreboard #(
    parameter int SAMPLES_PER_FRAME = 64,
    parameter int CHANNELS          = 8,
    parameter int PENDING_DEPTH     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        frame_valid,
    input  logic        frame_stall,
    input  logic [31:0] source_ip,
    input  logic [10:0] point_index,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  kind,
    input  logic [2:0]  channel,
    input  logic [10:0] request_point,
    input  logic [31:0] frame_number,
    input  logic        table_full,
    input  logic        last,
    output int          errors,
    output int          outstanding
);

    typedef struct {
        fgrt_pkg::kind_t kind;
        logic [2:0]      ch;
        logic [10:0]     pt;
        logic [31:0]     num;
        logic            full;
        logic            fin;
    } beat_t;

    beat_t            want_q[$];
    beat_t            head;
    int               fails;
    logic [7:0]       enable_mask;
    logic [10:0]      last_pt [CHANNELS];
    logic [31:0]      frame_cnt [CHANNELS];
    fgrt_pkg::entry_t miss_tbl [PENDING_DEPTH];
    logic             miss_busy [PENDING_DEPTH];

    function automatic void queue_beat(fgrt_pkg::kind_t k, logic [2:0] ch, logic [10:0] pt,
                                       logic [31:0] num, logic full, logic fin);
        beat_t b;
        b.kind = k;
        b.ch   = ch;
        b.pt   = pt;
        b.num  = num;
        b.full = full;
        b.fin  = fin;
        want_q.insert(want_q.size(), b);
    endfunction

    function automatic void check_field(string what, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    task automatic track_frame(input logic [31:0] src, input logic [10:0] now);
        logic [2:0]  ch;
        bit          found;
        bit          full;
        logic [10:0] prev;
        logic [10:0] pt;
        logic [11:0] move;
        logic [31:0] base;
        int          frames;
        int          lost;
        int          emit;
        found = 1'b0;
        ch    = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (!found && enable_mask[c] &&
                src == fgrt_pkg::BASE_ADDR + fgrt_pkg::ADDR_STEP * 32'(c))
            begin
                ch    = 3'(c);
                found = 1'b1;
            end
        end
        if (!found)
        begin
            queue_beat(fgrt_pkg::KIND_IGNORED, '0, now, '0, 1'b0, 1'b1);
            return;
        end
        frame_cnt[ch] = frame_cnt[ch] + 32'd1;
        if (frame_cnt[ch] == 32'd1)
        begin
            last_pt[ch] = now;
            queue_beat(fgrt_pkg::KIND_ACCEPTED, ch, now, frame_cnt[ch], 1'b0, 1'b1);
            return;
        end
        // lowest matching entry is the retransmitted frame
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            if (miss_busy[i] && miss_tbl[i].ch == ch && miss_tbl[i].pt == now)
            begin
                miss_busy[i]  = 1'b0;
                frame_cnt[ch] = frame_cnt[ch] - 32'd1;
                queue_beat(fgrt_pkg::KIND_RETRANSMIT, ch, now, miss_tbl[i].num, 1'b0, 1'b1);
                return;
            end
        end
        prev = last_pt[ch];
        if (now > prev)
            move = {1'b0, now} - {1'b0, prev};
        else
            move = 12'd2048 + {1'b0, now} - {1'b0, prev};
        frames = int'(move) / SAMPLES_PER_FRAME;
        lost   = (frames > 0) ? frames - 1 : 0;
        emit   = (lost > fgrt_pkg::MAX_REQUESTS) ? fgrt_pkg::MAX_REQUESTS : lost;
        base   = frame_cnt[ch];
        for (int m = 0; m < emit; m++)
        begin
            pt   = prev + 11'((m + 1) * SAMPLES_PER_FRAME);
            full = 1'b1;
            for (int i = 0; i < PENDING_DEPTH; i++)
            begin
                if (full && !miss_busy[i])
                begin
                    miss_busy[i]    = 1'b1;
                    miss_tbl[i].ch  = ch;
                    miss_tbl[i].pt  = pt;
                    miss_tbl[i].num = base + 32'(m);
                    full            = 1'b0;
                end
            end
            queue_beat(fgrt_pkg::KIND_REQUEST, ch, pt, base + 32'(m), full, 1'b0);
        end
        frame_cnt[ch] = base + 32'(lost);
        last_pt[ch]   = now;
        queue_beat(fgrt_pkg::KIND_ACCEPTED, ch, now, frame_cnt[ch], lost > emit, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_q.delete();
            fails       = 0;
            enable_mask = '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                last_pt[c]   = '0;
                frame_cnt[c] = '0;
            end
            for (int i = 0; i < PENDING_DEPTH; i++)
                miss_busy[i] = 1'b0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (want_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result beat, expected none, got kind %0d point %0d",
                             $time, kind, request_point);
                end
                else
                begin
                    head = want_q.pop_front();
                    check_field("kind", head.kind, kind);
                    check_field("channel", head.ch, channel);
                    check_field("request_point", head.pt, request_point);
                    check_field("frame_number", head.num, frame_number);
                    check_field("table_full", head.full, table_full);
                    check_field("last", head.fin, last);
                end
            end
            if (cfg_valid && cfg_ready)
                enable_mask = cfg_data;
            if (frame_valid && !frame_stall)
                track_frame(source_ip, point_index);
            errors      <= fails;
            outstanding <= want_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// tb: stimulus and verdict for frame_gap_retransmit_tracker; directed headers, then
// random frame sequences with gaps, retransmits and noise. Depends on fgrt_pkg, fgrt_scoreboard.
module tb;

    localparam int SPF             = 64;
    localparam int CHANNELS        = 8;
    localparam int PENDING_DEPTH   = 32;
    localparam int LIMIT           = 2_000_000;
    localparam int ITEMS_PER_PHASE = 88;

    typedef struct packed {
        logic [2:0]  ch;
        logic [10:0] pt;
    } miss_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [7:0]  cfg_data     = '0;
    logic        frame_valid  = 1'b0;
    logic [31:0] source_ip    = '0;
    logic [10:0] point_index  = '0;
    logic        result_stall = 1'b0;
    logic        cfg_ready;
    logic        frame_stall;
    logic        result_valid;
    logic [1:0]  kind;
    logic [2:0]  channel;
    logic [10:0] request_point;
    logic [31:0] frame_number;
    logic        table_full;
    logic        last;
    int          errors;
    int          outstanding;

    miss_t       miss_q[$];
    logic [10:0] sent_pt [CHANNELS];
    logic [7:0]  mask_now   = '0;
    bit          calm       = 1'b0;
    int          stall_left = 0;
    int          cycles     = 0;

    frame_gap_retransmit_tracker #(
        .SAMPLES_PER_FRAME(SPF),
        .CHANNELS(CHANNELS),
        .PENDING_DEPTH(PENDING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .source_ip(source_ip),
        .point_index(point_index),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind(kind),
        .channel(channel),
        .request_point(request_point),
        .frame_number(frame_number),
        .table_full(table_full),
        .last(last)
    );

    fgrt_scoreboard #(
        .SAMPLES_PER_FRAME(SPF),
        .CHANNELS(CHANNELS),
        .PENDING_DEPTH(PENDING_DEPTH)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .source_ip(source_ip),
        .point_index(point_index),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .kind(kind),
        .channel(channel),
        .request_point(request_point),
        .frame_number(frame_number),
        .table_full(table_full),
        .last(last),
        .errors(errors),
        .outstanding(outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (calm || $urandom_range(0, 99) < 65)
            result_stall <= 1'b0;
        else
        begin
            result_stall <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    task automatic send_frame(input logic [31:0] src, input logic [10:0] pt);
        int gap;
        frame_valid <= 1'b1;
        source_ip   <= src;
        point_index <= pt;
        do @(posedge clk); while (frame_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_on(input int c, input logic [10:0] pt);
        sent_pt[c] = pt;
        send_frame(fgrt_pkg::BASE_ADDR + fgrt_pkg::ADDR_STEP * 32'(c), pt);
    endtask

    task automatic settle();
        frame_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mask(input logic [7:0] m);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mask_now = m;
    endtask

    task automatic random_item();
        int          r;
        int          c;
        int          k;
        int          j;
        miss_t       ms;
        logic [10:0] p;
        r = $urandom_range(0, 99);
        do c = $urandom_range(0, CHANNELS - 1); while (!mask_now[c]);
        p = sent_pt[c];
        if (r < 8)
            send_frame($urandom, 11'($urandom_range(0, 2047)));
        else if (r < 14)
            send_frame(fgrt_pkg::BASE_ADDR + fgrt_pkg::ADDR_STEP * 32'($urandom_range(0, 7)) +
                       32'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)));
        else if (r < 26 && miss_q.size() > 0)
        begin
            j  = $urandom_range(0, miss_q.size() - 1);
            ms = miss_q[j];
            miss_q.delete(j);
            send_frame(fgrt_pkg::BASE_ADDR + fgrt_pkg::ADDR_STEP * 32'(ms.ch), ms.pt);
        end
        else if (r < 32)
            send_on(c, p + 11'($urandom_range(1, SPF - 1)));
        else if (r < 36)
            send_on(c, 11'($urandom_range(0, 2047)));
        else if (r < 38)
            send_on(c, p);
        else if (r < 58)
        begin
            k = $urandom_range(1, 4);
            for (j = 1; j <= k; j++)
            begin
                ms.ch = 3'(c);
                ms.pt = p + 11'(j * SPF);
                miss_q.insert(miss_q.size(), ms);
            end
            while (miss_q.size() > 24)
                void'(miss_q.pop_front());
            send_on(c, p + 11'((k + 1) * SPF));
        end
        else
            send_on(c, p + 11'(SPF));
    endtask

    initial
    begin
        for (int c = 0; c < CHANNELS; c++)
            sent_pt[c] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mask(8'h00);
        send_on(0, 11'd5);
        write_mask(8'hFF);
        send_frame(32'd0, 11'd0);
        send_frame(32'hFFFF_FFFF, 11'd2047);
        send_frame(32'd80, 11'd3);
        send_on(0, 11'd0);
        send_on(0, 11'd64);
        send_on(0, 11'd100);
        send_on(0, 11'd356);
        send_frame(fgrt_pkg::BASE_ADDR, 11'd228);
        // full wrap: 31 requests, the table runs out on the last one
        send_on(0, 11'd356);
        send_on(7, 11'd2047);
        send_on(7, 11'd2047);
        // two entries hold pointer 164: lowest one first
        send_frame(fgrt_pkg::BASE_ADDR, 11'd164);
        send_frame(fgrt_pkg::BASE_ADDR, 11'd164);
        send_on(3, 11'd1000);
        send_on(3, 11'd1063);
        send_on(3, 11'd1191);
        send_on(3, 11'd2000);
        send_on(3, 11'd40);

        for (int ph = 0; ph < 5; ph++)
        begin
            unique case (ph)
                0: write_mask(8'hFF);
                1: write_mask(8'h81);
                2: write_mask(8'($urandom_range(1, 255)));
                3: write_mask(8'h01);
                default: write_mask(8'hFF);
            endcase
            calm = (ph == 0);
            repeat (ITEMS_PER_PHASE) random_item();
        end
        calm = 1'b0;

        frame_valid <= 1'b0;
        for (int w = 0; w < 20000 && (w == 0 || outstanding != 0); w++)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
